/* rtl/hcb_pkg.sv */
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int CNT_W           = 32;
    localparam int LEN_W           = 6;
    localparam int CODE_W          = 64;
    localparam int LIMIT_W         = 9;
    localparam int SYM_W           = 8;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0]   LEN_MAX     = 6'd63;

    typedef enum logic [2:0] {
        ACT_SET       = 3'd0,
        ACT_INC       = 3'd1,
        ACT_READ      = 3'd2,
        ACT_BUILD     = 3'd3,
        ACT_READ_CODE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_BUILT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SCAN,
        BK_PAD,
        BK_MSCAN,
        BK_MWA,
        BK_MWB,
        BK_MWN,
        BK_WRD,
        BK_WEV
    } t_back_state;

    typedef struct packed {
        logic [2:0]       action;
        logic [SYM_W-1:0] symbol;
        logic [CNT_W-1:0] new_freq;
        logic             in_range;
    } t_item;

endpackage

/* rtl/hcb_fifo.sv */
// ----------------------------------------------------------------------------
// hcb_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hcb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcb_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hcb_pkg::t_item o_head
);

    localparam int PW = $clog2(hcb_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(hcb_pkg::FIFO_DEPTH + 1);

    hcb_pkg::t_item r_mem [hcb_pkg::FIFO_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CW'(hcb_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(hcb_pkg::FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(hcb_pkg::FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* rtl/hcb_front.sv */
// ----------------------------------------------------------------------------
// hcb_front
// Holds the symbol limit, accepts input beats and classifies them.
// ----------------------------------------------------------------------------
module hcb_front #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int LW          = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hcb_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_action,
    input  logic [hcb_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcb_pkg::CNT_W-1:0]   i_new_frequency,
    input  logic                        i_fifo_full,
    output logic                        o_push,
    output hcb_pkg::t_item              o_item,
    output logic [LW-1:0]               o_limit
);

    localparam int CW = (LW > hcb_pkg::LIMIT_W) ? LW : hcb_pkg::LIMIT_W;

    logic [hcb_pkg::LIMIT_W-1:0] r_symbol_limit;
    logic [CW-1:0]               lim_ext;
    logic [CW-1:0]               lim_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_limit <= hcb_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_symbol_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        lim_ext = CW'(r_symbol_limit);
        if (lim_ext < CW'(2)) begin
            lim_sat = CW'(2);
        end else if (lim_ext > CW'(MAX_SYMBOLS)) begin
            lim_sat = CW'(MAX_SYMBOLS);
        end else begin
            lim_sat = lim_ext;
        end
    end

    assign o_limit    = LW'(lim_sat);
    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

    always_comb begin
        o_item.action   = i_action;
        o_item.symbol   = i_symbol;
        o_item.new_freq = i_new_frequency;
        o_item.in_range = (CW'(i_symbol) < lim_sat);
    end

endmodule

/* rtl/hcb_back.sv */
// ----------------------------------------------------------------------------
// hcb_back
// Executes queued items: counter table access, Huffman merge, code walk.
// ----------------------------------------------------------------------------
module hcb_back #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int LW          = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fifo_empty,
    input  hcb_pkg::t_item               i_head,
    output logic                         o_pop,
    input  logic [LW-1:0]                i_limit,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hcb_pkg::CNT_W-1:0]    o_frequency,
    output logic [hcb_pkg::LEN_W-1:0]    o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]   o_code_bits,
    output logic [1:0]                   o_status
);

    localparam int SW  = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int NS  = 2 * MAX_SYMBOLS;
    localparam int NW  = $clog2(NS);
    localparam int WW  = hcb_pkg::CNT_W + SW;
    localparam int DPW = (NW > 7) ? NW : 7;

    // storage
    logic [hcb_pkg::CNT_W-1:0]  cnt_mem  [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0]     r_cnt_vld;
    logic [hcb_pkg::LEN_W-1:0]  len_mem  [MAX_SYMBOLS];
    logic [hcb_pkg::CODE_W-1:0] code_mem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0]     r_built;
    logic [WW-1:0]              nd_w_mem    [NS];
    logic [SW-1:0]              nd_low_mem  [NS];
    logic [NW-1:0]              nd_par_mem  [NS];
    logic                       nd_hp_mem   [NS];
    logic                       nd_rt_mem   [NS];
    logic                       nd_live_mem [NS];

    // read data
    logic [hcb_pkg::CNT_W-1:0]  r_cnt_rd;
    logic                       r_cnt_rv;
    logic [hcb_pkg::LEN_W-1:0]  r_len_rd;
    logic [hcb_pkg::CODE_W-1:0] r_code_rd;
    logic                       r_built_rd;
    logic [WW-1:0]              r_nd_w;
    logic [SW-1:0]              r_nd_low;
    logic [NW-1:0]              r_nd_par;
    logic                       r_nd_hp;
    logic                       r_nd_rt;
    logic                       r_nd_live;

    // ports of the stores
    logic [SW-1:0]              cnt_ra;
    logic                       cnt_we;
    logic [SW-1:0]              cnt_wa;
    logic [hcb_pkg::CNT_W-1:0]  cnt_wd;
    logic [SW-1:0]              code_ra;
    logic                       code_we;
    logic [SW-1:0]              code_wa;
    logic [hcb_pkg::LEN_W-1:0]  len_wd;
    logic [hcb_pkg::CODE_W-1:0] code_wd;
    logic                       built_clr;
    logic [NW-1:0]              nd_ra;
    logic                       nd_we;
    logic [NW-1:0]              nd_wa;
    logic [WW-1:0]              nd_w_wd;
    logic [SW-1:0]              nd_low_wd;
    logic [NW-1:0]              nd_par_wd;
    logic                       nd_hp_wd;
    logic                       nd_rt_wd;
    logic                       nd_live_wd;

    // control
    hcb_pkg::t_back_state       r_state, n_state;
    hcb_pkg::t_item             r_item, n_item;
    logic                       r_codes_valid, n_codes_valid;
    logic                       r_out_valid, n_out_valid;
    logic [hcb_pkg::CNT_W-1:0]  r_out_freq, n_out_freq;
    logic [hcb_pkg::LEN_W-1:0]  r_out_len, n_out_len;
    logic [hcb_pkg::CODE_W-1:0] r_out_bits, n_out_bits;
    logic [1:0]                 r_out_st, n_out_st;

    // build
    logic [LW-1:0]              r_s, n_s;
    logic                       r_p_vld, n_p_vld;
    logic [SW-1:0]              r_p_sym, n_p_sym;
    logic [NW-1:0]              r_used, n_used;
    logic [1:0]                 r_nz, n_nz;
    logic [SW-1:0]              r_z0, n_z0;
    logic [SW-1:0]              r_z1, n_z1;
    logic                       r_pad, n_pad;
    logic [LW-1:0]              r_live, n_live;
    logic [NW-1:0]              r_leaves, n_leaves;
    logic [NW-1:0]              r_i, n_i;
    logic                       r_q_vld, n_q_vld;
    logic [NW-1:0]              r_q_idx, n_q_idx;
    logic                       r_f1, n_f1;
    logic                       r_f2, n_f2;
    logic [NW-1:0]              r_b1_idx, n_b1_idx;
    logic [WW-1:0]              r_b1_w, n_b1_w;
    logic [SW-1:0]              r_b1_low, n_b1_low;
    logic [NW-1:0]              r_b2_idx, n_b2_idx;
    logic [WW-1:0]              r_b2_w, n_b2_w;
    logic [SW-1:0]              r_b2_low, n_b2_low;
    logic [NW-1:0]              r_leaf, n_leaf;
    logic [NW-1:0]              r_n, n_n;
    logic [DPW-1:0]             r_depth, n_depth;
    logic [hcb_pkg::CODE_W-1:0] r_code, n_code;
    logic [SW-1:0]              r_wsym, n_wsym;
    logic                       r_first, n_first;

    logic [hcb_pkg::CNT_W-1:0]  cur_cnt;
    logic                       out_free;
    logic [SW-1:0]              item_idx;
    logic [SW-1:0]              head_idx;
    logic [SW-1:0]              sym_now;
    logic                       lt_b1;
    logic                       lt_b2;

    assign item_idx = SW'(r_item.symbol);
    assign head_idx = SW'(i_head.symbol);
    assign cur_cnt  = r_cnt_rv ? r_cnt_rd : '0;
    assign out_free = !r_out_valid || !i_out_stall;
    assign lt_b1    = {r_nd_w, r_nd_low} < {r_b1_w, r_b1_low};
    assign lt_b2    = {r_nd_w, r_nd_low} < {r_b2_w, r_b2_low};
    assign sym_now  = r_first ? r_nd_low : r_wsym;

    assign o_out_valid   = r_out_valid;
    assign o_frequency   = r_out_freq;
    assign o_code_length = r_out_len;
    assign o_code_bits   = r_out_bits;
    assign o_status      = r_out_st;

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_codes_valid = r_codes_valid;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_freq    = r_out_freq;
        n_out_len     = r_out_len;
        n_out_bits    = r_out_bits;
        n_out_st      = r_out_st;
        n_s           = r_s;
        n_p_vld       = r_p_vld;
        n_p_sym       = r_p_sym;
        n_used        = r_used;
        n_nz          = r_nz;
        n_z0          = r_z0;
        n_z1          = r_z1;
        n_pad         = r_pad;
        n_live        = r_live;
        n_leaves      = r_leaves;
        n_i           = r_i;
        n_q_vld       = r_q_vld;
        n_q_idx       = r_q_idx;
        n_f1          = r_f1;
        n_f2          = r_f2;
        n_b1_idx      = r_b1_idx;
        n_b1_w        = r_b1_w;
        n_b1_low      = r_b1_low;
        n_b2_idx      = r_b2_idx;
        n_b2_w        = r_b2_w;
        n_b2_low      = r_b2_low;
        n_leaf        = r_leaf;
        n_n           = r_n;
        n_depth       = r_depth;
        n_code        = r_code;
        n_wsym        = r_wsym;
        n_first       = r_first;

        o_pop      = 1'b0;
        cnt_ra     = item_idx;
        cnt_we     = 1'b0;
        cnt_wa     = item_idx;
        cnt_wd     = r_item.new_freq;
        code_ra    = item_idx;
        code_we    = 1'b0;
        code_wa    = sym_now;
        len_wd     = '0;
        code_wd    = r_code;
        built_clr  = 1'b0;
        nd_ra      = r_n;
        nd_we      = 1'b0;
        nd_wa      = r_used;
        nd_w_wd    = '0;
        nd_low_wd  = '0;
        nd_par_wd  = '0;
        nd_hp_wd   = 1'b0;
        nd_rt_wd   = 1'b0;
        nd_live_wd = 1'b1;

        case (r_state)
            hcb_pkg::BK_IDLE: begin
                cnt_ra  = head_idx;
                code_ra = head_idx;
                if (!i_fifo_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_head;
                    if (i_head.action == hcb_pkg::ACT_BUILD) begin
                        built_clr = 1'b1;
                        n_s       = '0;
                        n_p_vld   = 1'b0;
                        n_used    = '0;
                        n_nz      = '0;
                        n_pad     = 1'b0;
                        n_state   = hcb_pkg::BK_SCAN;
                    end else begin
                        n_state = hcb_pkg::BK_EXEC;
                    end
                end
            end
            hcb_pkg::BK_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_freq  = '0;
                    n_out_len   = '0;
                    n_out_bits  = '0;
                    n_out_st    = hcb_pkg::ST_OK;
                    n_state     = hcb_pkg::BK_IDLE;
                    case (r_item.action)
                        hcb_pkg::ACT_SET: begin
                            if (!r_item.in_range) begin
                                n_out_st = hcb_pkg::ST_RANGE;
                            end else begin
                                cnt_we     = 1'b1;
                                n_out_freq = r_item.new_freq;
                            end
                        end
                        hcb_pkg::ACT_INC: begin
                            if (!r_item.in_range) begin
                                n_out_st = hcb_pkg::ST_RANGE;
                            end else if (cur_cnt == hcb_pkg::CNT_MAX) begin
                                n_out_st   = hcb_pkg::ST_OVERFLOW;
                                n_out_freq = cur_cnt;
                            end else begin
                                cnt_we     = 1'b1;
                                cnt_wd     = cur_cnt + 1'b1;
                                n_out_freq = cur_cnt + 1'b1;
                            end
                        end
                        hcb_pkg::ACT_READ: begin
                            if (!r_item.in_range) begin
                                n_out_st = hcb_pkg::ST_RANGE;
                            end else begin
                                n_out_freq = cur_cnt;
                            end
                        end
                        hcb_pkg::ACT_READ_CODE: begin
                            if (!r_item.in_range) begin
                                n_out_st = hcb_pkg::ST_RANGE;
                            end else if (!r_codes_valid) begin
                                n_out_st = hcb_pkg::ST_NOT_BUILT;
                            end else if (r_built_rd) begin
                                n_out_len  = r_len_rd;
                                n_out_bits = r_code_rd;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hcb_pkg::BK_SCAN: begin
                cnt_ra = SW'(r_s);
                if (r_s < i_limit) begin
                    n_s     = r_s + 1'b1;
                    n_p_vld = 1'b1;
                    n_p_sym = SW'(r_s);
                end else begin
                    n_p_vld = 1'b0;
                end
                if (r_p_vld) begin
                    if (cur_cnt != '0) begin
                        nd_we     = 1'b1;
                        nd_w_wd   = WW'(cur_cnt);
                        nd_low_wd = r_p_sym;
                        n_used    = r_used + 1'b1;
                    end else if (r_nz == 2'd0) begin
                        n_z0 = r_p_sym;
                        n_nz = 2'd1;
                    end else if (r_nz == 2'd1) begin
                        n_z1 = r_p_sym;
                        n_nz = 2'd2;
                    end
                end
                if (r_s == i_limit && !r_p_vld) begin
                    n_state = hcb_pkg::BK_PAD;
                end
            end
            hcb_pkg::BK_PAD: begin
                if (r_used < NW'(2)) begin
                    nd_we     = 1'b1;
                    nd_low_wd = r_pad ? r_z1 : r_z0;
                    n_used    = r_used + 1'b1;
                    n_pad     = 1'b1;
                end else begin
                    n_leaves = r_used;
                    n_live   = LW'(r_used);
                    n_i      = '0;
                    n_q_vld  = 1'b0;
                    n_f1     = 1'b0;
                    n_f2     = 1'b0;
                    n_state  = hcb_pkg::BK_MSCAN;
                end
            end
            hcb_pkg::BK_MSCAN: begin
                nd_ra = r_i;
                if (r_live <= LW'(1)) begin
                    n_leaf  = '0;
                    n_n     = '0;
                    n_depth = '0;
                    n_code  = '0;
                    n_first = 1'b1;
                    n_state = hcb_pkg::BK_WRD;
                end else begin
                    if (r_i < r_used) begin
                        n_i     = r_i + 1'b1;
                        n_q_vld = 1'b1;
                        n_q_idx = r_i;
                    end else begin
                        n_q_vld = 1'b0;
                    end
                    if (r_q_vld && r_nd_live) begin
                        if (!r_f1 || lt_b1) begin
                            n_f2     = r_f1;
                            n_b2_idx = r_b1_idx;
                            n_b2_w   = r_b1_w;
                            n_b2_low = r_b1_low;
                            n_f1     = 1'b1;
                            n_b1_idx = r_q_idx;
                            n_b1_w   = r_nd_w;
                            n_b1_low = r_nd_low;
                        end else if (!r_f2 || lt_b2) begin
                            n_f2     = 1'b1;
                            n_b2_idx = r_q_idx;
                            n_b2_w   = r_nd_w;
                            n_b2_low = r_nd_low;
                        end
                    end
                    if (r_i == r_used && !r_q_vld) begin
                        n_state = hcb_pkg::BK_MWA;
                    end
                end
            end
            hcb_pkg::BK_MWA: begin
                nd_we      = 1'b1;
                nd_wa      = r_b1_idx;
                nd_w_wd    = r_b1_w;
                nd_low_wd  = r_b1_low;
                nd_par_wd  = r_used;
                nd_hp_wd   = 1'b1;
                nd_live_wd = 1'b0;
                n_state    = hcb_pkg::BK_MWB;
            end
            hcb_pkg::BK_MWB: begin
                nd_we      = 1'b1;
                nd_wa      = r_b2_idx;
                nd_w_wd    = r_b2_w;
                nd_low_wd  = r_b2_low;
                nd_par_wd  = r_used;
                nd_hp_wd   = 1'b1;
                nd_rt_wd   = 1'b1;
                nd_live_wd = 1'b0;
                n_state    = hcb_pkg::BK_MWN;
            end
            hcb_pkg::BK_MWN: begin
                nd_we     = 1'b1;
                nd_w_wd   = r_b1_w + r_b2_w;
                nd_low_wd = (r_b1_low < r_b2_low) ? r_b1_low : r_b2_low;
                n_used    = r_used + 1'b1;
                n_live    = r_live - 1'b1;
                n_i       = '0;
                n_q_vld   = 1'b0;
                n_f1      = 1'b0;
                n_f2      = 1'b0;
                n_state   = hcb_pkg::BK_MSCAN;
            end
            hcb_pkg::BK_WRD: begin
                nd_ra   = r_n;
                n_state = hcb_pkg::BK_WEV;
            end
            hcb_pkg::BK_WEV: begin
                if (r_first) begin
                    n_wsym  = r_nd_low;
                    n_first = 1'b0;
                end
                if (r_nd_hp) begin
                    if (r_depth < DPW'(64) && r_nd_rt) begin
                        n_code = r_code | (hcb_pkg::CODE_W'(1) << r_depth[5:0]);
                    end
                    n_depth = r_depth + 1'b1;
                    n_n     = r_nd_par;
                    n_state = hcb_pkg::BK_WRD;
                end else begin
                    code_we = 1'b1;
                    len_wd  = (r_depth > DPW'(hcb_pkg::LEN_MAX)) ? hcb_pkg::LEN_MAX
                                                                 : r_depth[5:0];
                    n_leaf  = r_leaf + 1'b1;
                    if (r_leaf + 1'b1 == r_leaves) begin
                        n_codes_valid = 1'b1;
                        n_state       = hcb_pkg::BK_EXEC;
                    end else begin
                        n_n     = r_leaf + 1'b1;
                        n_depth = '0;
                        n_code  = '0;
                        n_first = 1'b1;
                        n_state = hcb_pkg::BK_WRD;
                    end
                end
            end
            default: begin
                n_state = hcb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hcb_pkg::BK_IDLE;
            r_codes_valid <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt_vld     <= '0;
            r_built       <= '0;
            r_p_vld       <= 1'b0;
            r_q_vld       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_codes_valid <= n_codes_valid;
            r_out_valid   <= n_out_valid;
            r_p_vld       <= n_p_vld;
            r_q_vld       <= n_q_vld;
            if (cnt_we) begin
                r_cnt_vld[cnt_wa] <= 1'b1;
            end
            if (built_clr) begin
                r_built <= '0;
            end else if (code_we) begin
                r_built[code_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out_freq <= n_out_freq;
        r_out_len  <= n_out_len;
        r_out_bits <= n_out_bits;
        r_out_st   <= n_out_st;
        r_s        <= n_s;
        r_p_sym    <= n_p_sym;
        r_used     <= n_used;
        r_nz       <= n_nz;
        r_z0       <= n_z0;
        r_z1       <= n_z1;
        r_pad      <= n_pad;
        r_live     <= n_live;
        r_leaves   <= n_leaves;
        r_i        <= n_i;
        r_q_idx    <= n_q_idx;
        r_f1       <= n_f1;
        r_f2       <= n_f2;
        r_b1_idx   <= n_b1_idx;
        r_b1_w     <= n_b1_w;
        r_b1_low   <= n_b1_low;
        r_b2_idx   <= n_b2_idx;
        r_b2_w     <= n_b2_w;
        r_b2_low   <= n_b2_low;
        r_leaf     <= n_leaf;
        r_n        <= n_n;
        r_depth    <= n_depth;
        r_code     <= n_code;
        r_wsym     <= n_wsym;
        r_first    <= n_first;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_rd <= cnt_mem[cnt_ra];
        r_cnt_rv <= r_cnt_vld[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (code_we) begin
            len_mem[code_wa]  <= len_wd;
            code_mem[code_wa] <= code_wd;
        end
        r_len_rd   <= len_mem[code_ra];
        r_code_rd  <= code_mem[code_ra];
        r_built_rd <= r_built[code_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            nd_w_mem[nd_wa]    <= nd_w_wd;
            nd_low_mem[nd_wa]  <= nd_low_wd;
            nd_par_mem[nd_wa]  <= nd_par_wd;
            nd_hp_mem[nd_wa]   <= nd_hp_wd;
            nd_rt_mem[nd_wa]   <= nd_rt_wd;
            nd_live_mem[nd_wa] <= nd_live_wd;
        end
        r_nd_w    <= nd_w_mem[nd_ra];
        r_nd_low  <= nd_low_mem[nd_ra];
        r_nd_par  <= nd_par_mem[nd_ra];
        r_nd_hp   <= nd_hp_mem[nd_ra];
        r_nd_rt   <= nd_rt_mem[nd_ra];
        r_nd_live <= nd_live_mem[nd_ra];
    end

endmodule

/* rtl/huffman_code_builder_top.sv */
// ----------------------------------------------------------------------------
// huffman_code_builder_top
// Frequency counters per symbol and Huffman code construction.
//
//   channel  signals                                    direction
//   cfg      i_cfg_we, i_cfg_wdata                      in, write only
//   in       i_in_valid/o_in_stall, action/symbol/freq  in
//   out      o_out_valid/i_out_stall, freq/len/bits/st  out
//
// Set, increment, read and read-code pass through the back end as a queue
// pop, then a registered table read; the front keeps accepting while the
// two-entry queue has room.
// Build scans the leaves up to the limit, pads with zero-count symbols up to
// two leaves, makes one pass over the node store for each merge, then walks
// every leaf's path to the root, on one node-store read and one write port.
// Reset is synchronous; the counter and code tables read as zero after it.
// ----------------------------------------------------------------------------
module huffman_code_builder_top #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hcb_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_action,
    input  logic [hcb_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hcb_pkg::CNT_W-1:0]    i_new_frequency,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hcb_pkg::CNT_W-1:0]    o_frequency,
    output logic [hcb_pkg::LEN_W-1:0]    o_code_length,
    output logic [hcb_pkg::CODE_W-1:0]   o_code_bits,
    output logic [1:0]                   o_status
);

    localparam int LW = $clog2(MAX_SYMBOLS + 1);

    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    hcb_pkg::t_item front_item;
    hcb_pkg::t_item head_item;
    logic [LW-1:0]  limit;

    hcb_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .LW          (LW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_symbol        (i_symbol),
        .i_new_frequency (i_new_frequency),
        .i_fifo_full     (fifo_full),
        .o_push          (push),
        .o_item          (front_item),
        .o_limit         (limit)
    );

    hcb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_head  (head_item)
    );

    hcb_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .LW          (LW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_empty  (fifo_empty),
        .i_head        (head_item),
        .o_pop         (pop),
        .i_limit       (limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frequency   (o_frequency),
        .o_code_length (o_code_length),
        .o_code_bits   (o_code_bits),
        .o_status      (o_status)
    );

endmodule

/* sim/huffman_code_builder_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_builder_top_tb
// Self-checking bench for the Huffman code builder: a directed table of
// counter, build and read-code beats, then randomized phases over several
// alphabet sizes, each result compared with its table entry or an in-bench model.
// ----------------------------------------------------------------------------
module huffman_code_builder_top_tb;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int         NODES        = 512;
    localparam int         NO_PARENT    = -1;
    localparam int         STALL_LIMIT  = 1000000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 10;

    typedef struct {
        logic [hcb_pkg::CNT_W-1:0]  freq;
        logic [hcb_pkg::LEN_W-1:0]  len;
        logic [hcb_pkg::CODE_W-1:0] bits;
        logic [1:0]                 st;
    } t_code_result;

    typedef struct {
        bit                          is_cfg;
        logic [hcb_pkg::LIMIT_W-1:0] cfg_val;
        logic [2:0]                  act;
        logic [hcb_pkg::SYM_W-1:0]   sym;
        logic [hcb_pkg::CNT_W-1:0]   nf;
        bit                          typed;
        t_code_result                res;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hcb_pkg::LIMIT_W-1:0]   i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [2:0]                    i_action;
    logic [hcb_pkg::SYM_W-1:0]     i_symbol;
    logic [hcb_pkg::CNT_W-1:0]     i_new_frequency;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [hcb_pkg::CNT_W-1:0]     o_frequency;
    logic [hcb_pkg::LEN_W-1:0]     o_code_length;
    logic [hcb_pkg::CODE_W-1:0]    o_code_bits;
    logic [1:0]                    o_status;

    // model state
    logic [hcb_pkg::LIMIT_W-1:0]   limit_reg;
    logic [hcb_pkg::CNT_W-1:0]     counts [256];
    logic [hcb_pkg::LEN_W-1:0]     lengths [256];
    logic [hcb_pkg::CODE_W-1:0]    codes [256];
    bit                            built;
    longint unsigned               nd_weight [NODES];
    int                            nd_low [NODES];
    int                            nd_parent [NODES];
    bit                            nd_right [NODES];
    bit                            nd_live [NODES];

    t_code_result                  pending_q [$];
    t_stim_row                     table_q [$];
    int                            errors;
    int                            idle_cycles;
    int                            rx_wait;
    bit                            no_idle;
    bit                            long_hold;

    huffman_code_builder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_symbol        (i_symbol),
        .i_new_frequency (i_new_frequency),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frequency     (o_frequency),
        .o_code_length   (o_code_length),
        .o_code_bits     (o_code_bits),
        .o_status        (o_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int active_limit();
        if (limit_reg < 2) return 2;
        if (limit_reg > 256) return 256;
        return int'(limit_reg);
    endfunction

    function automatic int pop_lightest(int used);
        int best;
        bit found;
        best = 0;
        found = 0;
        for (int i = 0; i < used; i++) begin
            if (!nd_live[i]) continue;
            if (!found || nd_weight[i] < nd_weight[best] ||
                (nd_weight[i] == nd_weight[best] && nd_low[i] < nd_low[best])) begin
                best = i;
                found = 1;
            end
        end
        nd_live[best] = 0;
        return best;
    endfunction

    function automatic void add_node(int idx, longint unsigned w, int low);
        nd_weight[idx] = w;
        nd_low[idx]    = low;
        nd_parent[idx] = NO_PARENT;
        nd_right[idx]  = 0;
        nd_live[idx]   = 1;
    endfunction

    function automatic void build_code_tables();
        int lim;
        int used;
        int leaves;
        int live;
        int a;
        int b;
        int depth;
        int n;
        logic [hcb_pkg::CODE_W-1:0] code;
        lim = active_limit();
        used = 0;
        for (int i = 0; i < NODES; i++) nd_live[i] = 0;
        for (int s = 0; s < lim; s++) begin
            if (counts[s] != 0) begin
                add_node(used, counts[s], s);
                used++;
            end
        end
        for (int s = 0; s < lim && used < 2; s++) begin
            if (counts[s] == 0) begin
                add_node(used, 0, s);
                used++;
            end
        end
        leaves = used;
        live = used;
        while (live > 1 && used < NODES) begin
            a = pop_lightest(used);
            b = pop_lightest(used);
            add_node(used, nd_weight[a] + nd_weight[b],
                     nd_low[a] < nd_low[b] ? nd_low[a] : nd_low[b]);
            nd_parent[a] = used;
            nd_right[a]  = 0;
            nd_parent[b] = used;
            nd_right[b]  = 1;
            used++;
            live--;
        end
        for (int s = 0; s < 256; s++) begin
            lengths[s] = '0;
            codes[s]   = '0;
        end
        for (int i = 0; i < leaves; i++) begin
            depth = 0;
            code  = '0;
            n     = i;
            while (nd_parent[n] != NO_PARENT && depth < NODES) begin
                if (depth < 64 && nd_right[n]) code[depth] = 1'b1;
                depth++;
                n = nd_parent[n];
            end
            lengths[nd_low[i]] = depth > 63 ? hcb_pkg::LEN_MAX : hcb_pkg::LEN_W'(depth);
            codes[nd_low[i]]   = code;
        end
        built = 1;
    endfunction

    function automatic t_code_result apply_action(logic [2:0] act,
                                                  logic [hcb_pkg::SYM_W-1:0] sym,
                                                  logic [hcb_pkg::CNT_W-1:0] nf);
        t_code_result r;
        bit ok;
        r = '{freq: '0, len: '0, bits: '0, st: hcb_pkg::ST_OK};
        ok = int'(sym) < active_limit();
        case (act)
            hcb_pkg::ACT_SET: begin
                if (!ok) r.st = hcb_pkg::ST_RANGE;
                else begin
                    counts[sym] = nf;
                    r.freq = nf;
                end
            end
            hcb_pkg::ACT_INC: begin
                if (!ok) r.st = hcb_pkg::ST_RANGE;
                else begin
                    if (counts[sym] == hcb_pkg::CNT_MAX) r.st = hcb_pkg::ST_OVERFLOW;
                    else counts[sym] = counts[sym] + 1;
                    r.freq = counts[sym];
                end
            end
            hcb_pkg::ACT_READ: begin
                if (!ok) r.st = hcb_pkg::ST_RANGE;
                else r.freq = counts[sym];
            end
            hcb_pkg::ACT_BUILD: build_code_tables();
            hcb_pkg::ACT_READ_CODE: begin
                if (!ok) r.st = hcb_pkg::ST_RANGE;
                else if (!built) r.st = hcb_pkg::ST_NOT_BUILT;
                else begin
                    r.len  = lengths[sym];
                    r.bits = codes[sym];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one beat; called and returns at a falling edge
    task automatic send_beat(logic [2:0] act, logic [hcb_pkg::SYM_W-1:0] sym,
                             logic [hcb_pkg::CNT_W-1:0] nf,
                             bit typed, t_code_result typed_res);
        int gap;
        t_code_result r;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action        = act;
        i_symbol        = sym;
        i_new_frequency = nf;
        i_in_valid      = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        r = apply_action(act, sym, nf);
        pending_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic write_limit(logic [hcb_pkg::LIMIT_W-1:0] v);
        i_in_valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        limit_reg   = v;
    endtask

    task automatic add_row(logic [2:0] act, logic [hcb_pkg::SYM_W-1:0] sym,
                           logic [hcb_pkg::CNT_W-1:0] nf);
        t_stim_row row;
        row = '{is_cfg: 0, cfg_val: '0, act: act, sym: sym, nf: nf, typed: 0,
                res: '{freq: '0, len: '0, bits: '0, st: hcb_pkg::ST_OK}};
        table_q.push_back(row);
    endtask

    task automatic add_known(logic [2:0] act, logic [hcb_pkg::SYM_W-1:0] sym,
                             logic [hcb_pkg::CNT_W-1:0] nf,
                             logic [hcb_pkg::CNT_W-1:0] f, logic [hcb_pkg::LEN_W-1:0] l,
                             logic [hcb_pkg::CODE_W-1:0] b, hcb_pkg::t_status st);
        t_stim_row row;
        row = '{is_cfg: 0, cfg_val: '0, act: act, sym: sym, nf: nf, typed: 1,
                res: '{freq: f, len: l, bits: b, st: st}};
        table_q.push_back(row);
    endtask

    task automatic add_cfg(logic [hcb_pkg::LIMIT_W-1:0] v);
        t_stim_row row;
        row = '{is_cfg: 1, cfg_val: v, act: '0, sym: '0, nf: '0, typed: 0,
                res: '{freq: '0, len: '0, bits: '0, st: hcb_pkg::ST_OK}};
        table_q.push_back(row);
    endtask

    task automatic run_phase(logic [hcb_pkg::LIMIT_W-1:0] lim_val, int n_items, bit quiet,
                             bit hold_rx, bit big);
        int lim;
        int pick;
        logic [2:0] act;
        logic [hcb_pkg::SYM_W-1:0] sym;
        logic [hcb_pkg::CNT_W-1:0] nf;
        t_code_result none;
        none = '{freq: '0, len: '0, bits: '0, st: hcb_pkg::ST_OK};
        write_limit(lim_val);
        no_idle = quiet;
        lim = active_limit();
        if (hold_rx) long_hold = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2 && hold_rx) begin
                i_in_valid = 1'b0;
                wait (pending_q.size() == 0);
                @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) act = hcb_pkg::ACT_SET;
            else if (pick < 52) act = hcb_pkg::ACT_INC;
            else if (pick < 64) act = hcb_pkg::ACT_READ;
            else if (pick < 70) act = big ? hcb_pkg::ACT_READ : hcb_pkg::ACT_BUILD;
            else if (pick < 97) act = hcb_pkg::ACT_READ_CODE;
            else act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            if (k == n_items - 2) act = hcb_pkg::ACT_BUILD;
            if ($urandom_range(0, 9) == 0) sym = 8'($urandom_range(0, 255));
            else sym = 8'($urandom_range(0, lim - 1));
            pick = $urandom_range(0, 9);
            if (pick < 2) nf = '0;
            else if (pick < 6) nf = $urandom_range(1, 20);
            else if (pick < 8) nf = $urandom;
            else nf = hcb_pkg::CNT_MAX - $urandom_range(0, 3);
            send_beat(act, sym, nf, 0, none);
        end
        i_in_valid = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_code_result e;
        if (o_out_valid && !i_out_stall) begin
            rx_wait <= no_idle ? 0 : $urandom_range(0, 6);
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat freq=%h len=%0d bits=%h st=%0d", $time,
                         o_frequency, o_code_length, o_code_bits, o_status);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_frequency !== e.freq) begin
                    $display("%0t: frequency expected %h actual %h", $time, e.freq, o_frequency);
                    errors++;
                end
                if (o_code_length !== e.len) begin
                    $display("%0t: code_length expected %0d actual %0d", $time, e.len,
                             o_code_length);
                    errors++;
                end
                if (o_code_bits !== e.bits) begin
                    $display("%0t: code_bits expected %h actual %h", $time, e.bits, o_code_bits);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, o_status);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (rx_wait > 0) begin
                i_out_stall = 1'b1;
                rx_wait--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors          = 0;
        idle_cycles     = 0;
        rx_wait         = 0;
        no_idle         = 0;
        long_hold       = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_action        = '0;
        i_symbol        = '0;
        i_new_frequency = '0;
        i_out_stall     = 1'b0;
        limit_reg       = hcb_pkg::LIMIT_RESET;
        built           = 0;
        for (int s = 0; s < 256; s++) begin
            counts[s]  = '0;
            lengths[s] = '0;
            codes[s]   = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_known(hcb_pkg::ACT_READ_CODE, 0, 0, 0, 0, 0, hcb_pkg::ST_NOT_BUILT);
        add_known(hcb_pkg::ACT_READ, 255, 0, 0, 0, 0, hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_SET, 255, hcb_pkg::CNT_MAX, hcb_pkg::CNT_MAX, 0, 0,
                  hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_INC, 255, 0, hcb_pkg::CNT_MAX, 0, 0, hcb_pkg::ST_OVERFLOW);
        add_known(hcb_pkg::ACT_INC, 0, 0, 1, 0, 0, hcb_pkg::ST_OK);
        add_known(ACT_SPARE_LO, 7, 123, 0, 0, 0, hcb_pkg::ST_OK);
        add_known(ACT_SPARE_HI, 255, hcb_pkg::CNT_MAX, 0, 0, 0, hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_BUILD, 8'hAA, 32'h5555_5555, 0, 0, 0, hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_READ_CODE, 0, 0, 0, 1, 0, hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_READ_CODE, 255, 0, 0, 1, 1, hcb_pkg::ST_OK);
        add_known(hcb_pkg::ACT_READ_CODE, 17, 0, 0, 0, 0, hcb_pkg::ST_OK);
        add_cfg(3);
        add_known(hcb_pkg::ACT_INC, 3, 0, 0, 0, 0, hcb_pkg::ST_RANGE);
        add_known(hcb_pkg::ACT_SET, 200, 5, 0, 0, 0, hcb_pkg::ST_RANGE);
        add_known(hcb_pkg::ACT_READ_CODE, 255, 0, 0, 0, 0, hcb_pkg::ST_RANGE);
        add_known(hcb_pkg::ACT_READ_CODE, 0, 0, 0, 1, 0, hcb_pkg::ST_OK);
        add_row(hcb_pkg::ACT_SET, 1, 7);
        add_row(hcb_pkg::ACT_SET, 2, 7);
        add_row(hcb_pkg::ACT_BUILD, 0, 0);
        add_row(hcb_pkg::ACT_READ_CODE, 0, 0);
        add_row(hcb_pkg::ACT_READ_CODE, 1, 0);
        add_row(hcb_pkg::ACT_READ_CODE, 2, 0);
        add_cfg(0);
        add_row(hcb_pkg::ACT_SET, 0, 0);
        add_row(hcb_pkg::ACT_SET, 1, 0);
        add_row(hcb_pkg::ACT_BUILD, 0, 0);
        add_row(hcb_pkg::ACT_READ_CODE, 1, 0);

        foreach (table_q[i]) begin
            if (table_q[i].is_cfg) write_limit(table_q[i].cfg_val);
            else send_beat(table_q[i].act, table_q[i].sym, table_q[i].nf,
                           table_q[i].typed, table_q[i].res);
        end

        run_phase(9'd511, 40, 0, 0, 1);
        run_phase(9'd2, 120, 0, 0, 0);
        run_phase(9'd0, 100, 1, 0, 0);
        run_phase(9'd1, 100, 0, 0, 0);
        run_phase(9'd3, 120, 0, 0, 0);
        run_phase(9'd4, 120, 0, 1, 0);
        run_phase(9'd5, 120, 1, 0, 0);
        run_phase(9'd8, 140, 0, 0, 0);
        run_phase(9'd12, 140, 0, 0, 0);
        run_phase(9'd16, 140, 0, 0, 0);
        run_phase(9'd33, 120, 1, 0, 0);
        run_phase(9'($urandom_range(2, 64)), 120, 0, 0, 0);
        run_phase(9'd100, 40, 0, 0, 1);
        run_phase(9'd255, 40, 0, 0, 1);
        run_phase(9'd256, 40, 0, 0, 1);

        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
